>>> rtl/tfcc_pkg.sv
// Shared types and constants of the tagged four-channel concentrator FIFO.
// Depends on nothing; tfcc_ctrl and the top level use it by scoped names.
`timescale 1ns / 1ps

package tfcc_pkg;

    // Ring depth in bytes. It must be even: bytes are stored as tag/data pairs.
    localparam int RING_DEPTH = 512;
    localparam int PAIR_DEPTH = RING_DEPTH / 2;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int PAIR_W     = PTR_W - 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int FILL_W     = 10;
    localparam int BYTE_W     = 8;
    localparam int PAIR_DW    = 2 * BYTE_W;
    localparam int CHAN_N     = 4;

    localparam logic OP_ARRIVAL  = 1'b0;
    localparam logic OP_TX_READY = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [CHAN_N-1:0] ready_mask;
        logic [BYTE_W-1:0] chan0_byte;
        logic [BYTE_W-1:0] chan1_byte;
        logic [BYTE_W-1:0] chan2_byte;
        logic [BYTE_W-1:0] chan3_byte;
    } item_t;

    typedef struct packed {
        logic               wr_en;
        logic [PAIR_W-1:0]  wr_addr;
        logic [PAIR_DW-1:0] wr_data;
        logic               rd_en;
        logic [PAIR_W-1:0]  rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic              send;
        logic              fwd;
        logic [BYTE_W-1:0] fwd_byte;
        logic              half;
        logic              dropped;
        logic [FILL_W-1:0] fill;
    } step_t;

endpackage

>>> rtl/tfcc_ring_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; holds the tag/data byte pairs of the concentrator ring.
`timescale 1ns / 1ps

module tfcc_ring_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tfcc_ctrl.sv
// Ring pointers, fill count and transmitter state of the concentrator FIFO.
// Depends on tfcc_pkg; drives the ring RAM and the result stage of the top level.
`timescale 1ns / 1ps

module tfcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  tfcc_pkg::item_t   item,
    output tfcc_pkg::ram_req_t ram_req,
    output tfcc_pkg::step_t   step
);

    logic [tfcc_pkg::PAIR_W-1:0] wr_pair_reg, wr_pair_next;
    logic [tfcc_pkg::PTR_W-1:0]  rd_slot_reg, rd_slot_next;
    logic [tfcc_pkg::CNT_W-1:0]  held_reg, held_next;
    logic                        idle_reg, idle_next;

    logic                        arrival;
    logic                        store;
    logic                        send;
    logic [1:0]                  chan;
    logic [tfcc_pkg::BYTE_W-1:0] data_byte;
    logic [tfcc_pkg::CNT_W-1:0]  held_written;

    always_comb
    begin
        priority if (item.ready_mask[0])
        begin
            chan      = 2'd0;
            data_byte = item.chan0_byte;
        end
        else if (item.ready_mask[1])
        begin
            chan      = 2'd1;
            data_byte = item.chan1_byte;
        end
        else if (item.ready_mask[2])
        begin
            chan      = 2'd2;
            data_byte = item.chan2_byte;
        end
        else
        begin
            chan      = 2'd3;
            data_byte = item.chan3_byte;
        end
    end

    always_comb
    begin
        arrival      = (item.opcode == tfcc_pkg::OP_ARRIVAL);
        store        = arrival &&
                       (held_reg <= tfcc_pkg::CNT_W'(tfcc_pkg::RING_DEPTH - 2));
        held_written = store ? held_reg + tfcc_pkg::CNT_W'(2) : held_reg;
        // A ready transmitter always asks; an arrival sends only to an idle one.
        send         = (!arrival || idle_reg) && (held_written != '0);
        held_next    = send ? held_written - tfcc_pkg::CNT_W'(1) : held_written;

        if (send)
        begin
            idle_next = 1'b0;
        end
        else if (!arrival)
        begin
            idle_next = 1'b1;
        end
        else
        begin
            idle_next = idle_reg;
        end

        if (!store)
        begin
            wr_pair_next = wr_pair_reg;
        end
        else if (wr_pair_reg == tfcc_pkg::PAIR_W'(tfcc_pkg::PAIR_DEPTH - 1))
        begin
            wr_pair_next = '0;
        end
        else
        begin
            wr_pair_next = wr_pair_reg + tfcc_pkg::PAIR_W'(1);
        end

        if (!send)
        begin
            rd_slot_next = rd_slot_reg;
        end
        else if (rd_slot_reg == tfcc_pkg::PTR_W'(tfcc_pkg::RING_DEPTH - 1))
        begin
            rd_slot_next = '0;
        end
        else
        begin
            rd_slot_next = rd_slot_reg + tfcc_pkg::PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pair_reg <= '0;
            rd_slot_reg <= '0;
            held_reg    <= '0;
            idle_reg    <= 1'b1;
        end
        else if (advance)
        begin
            wr_pair_reg <= wr_pair_next;
            rd_slot_reg <= rd_slot_next;
            held_reg    <= held_next;
            idle_reg    <= idle_next;
        end
    end

    // The tag sits in the low byte of a pair, the data byte in the high one.
    assign ram_req.wr_en   = advance && store;
    assign ram_req.wr_addr = wr_pair_reg;
    assign ram_req.wr_data = {data_byte, tfcc_pkg::BYTE_W'(chan)};
    assign ram_req.rd_en   = advance;
    assign ram_req.rd_addr = rd_slot_reg[tfcc_pkg::PTR_W-1:1];

    // With an empty ring the byte sent is the tag being written in this step.
    assign step.send     = send;
    assign step.fwd      = store && (held_reg == '0);
    assign step.fwd_byte = tfcc_pkg::BYTE_W'(chan);
    assign step.half     = rd_slot_reg[0];
    assign step.dropped  = arrival && !store;
    assign step.fill     = tfcc_pkg::FILL_W'(held_next);

endmodule

>>> rtl/tagged_four_channel_concentrator_fifo.sv
// Top level of the tagged four-channel concentrator FIFO.
// Depends on tfcc_pkg, tfcc_ctrl and tfcc_ring_ram.
`timescale 1ns / 1ps

// Four receive channels are merged into one serial byte stream through a ring
// of RING_DEPTH bytes. An arrival request takes the lowest-numbered channel
// flagged in ready_mask (channel 3 when none is flagged) and appends two bytes,
// the channel number and then that channel's data byte, as long as the ring
// holds at most RING_DEPTH - 2 bytes; otherwise the arrival is discarded and
// arrival_dropped is set. An idle transmitter gets the head byte at once; a
// transmitter-ready request sends the head byte or, with an empty ring, leaves
// the transmitter idle. Every request yields exactly one result, carrying the
// byte sent (zero when send_valid is low) and the fill level after the step.
// The block takes one request per clock cycle unless a stalled result holds
// it back; a request passes the input register and then the result stage with
// the registered read of the ring RAM. Pairs of bytes share one RAM word, so an
// arrival costs a single write. The ring needs no clearing pass after reset.
module tagged_four_channel_concentrator_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        opcode,
    input  logic [3:0]                  ready_mask,
    input  logic [7:0]                  chan0_byte,
    input  logic [7:0]                  chan1_byte,
    input  logic [7:0]                  chan2_byte,
    input  logic [7:0]                  chan3_byte,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        send_valid,
    output logic [7:0]                  send_byte,
    output logic                        arrival_dropped,
    output logic [9:0]                  fill_level
);

    // Input register: one request waiting for the ring update.
    logic              s0_valid_reg, s0_valid_next;
    tfcc_pkg::item_t   item_reg;

    // Result stage: control fields of the step plus the RAM read in flight.
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_send_reg;
    logic                          s1_fwd_reg;
    logic [tfcc_pkg::BYTE_W-1:0]   s1_fwd_byte_reg;
    logic                          s1_half_reg;
    logic                          s1_drop_reg;
    logic [tfcc_pkg::FILL_W-1:0]   s1_fill_reg;

    logic                          item_accept;
    logic                          s1_load;
    tfcc_pkg::ram_req_t            ram_req;
    tfcc_pkg::step_t               step;
    logic [tfcc_pkg::PAIR_DW-1:0]  rd_pair;
    logic [tfcc_pkg::BYTE_W-1:0]   head_byte;

    // The request in the input register moves on whenever the result stage is
    // empty or its result is being taken in this cycle.
    assign s1_load     = s0_valid_reg && (!s1_valid_reg || !result_stall);
    assign item_stall  = s0_valid_reg && !s1_load;
    assign item_accept = item_valid && !item_stall;

    always_comb
    begin
        if (item_accept)
        begin
            s0_valid_next = 1'b1;
        end
        else if (s1_load)
        begin
            s0_valid_next = 1'b0;
        end
        else
        begin
            s0_valid_next = s0_valid_reg;
        end

        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_valid_reg && !result_stall)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg.opcode     <= opcode;
            item_reg.ready_mask <= ready_mask;
            item_reg.chan0_byte <= chan0_byte;
            item_reg.chan1_byte <= chan1_byte;
            item_reg.chan2_byte <= chan2_byte;
            item_reg.chan3_byte <= chan3_byte;
        end
        if (s1_load)
        begin
            s1_send_reg     <= step.send;
            s1_fwd_reg      <= step.fwd;
            s1_fwd_byte_reg <= step.fwd_byte;
            s1_half_reg     <= step.half;
            s1_drop_reg     <= step.dropped;
            s1_fill_reg     <= step.fill;
        end
    end

    tfcc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_load),
        .item    (item_reg),
        .ram_req (ram_req),
        .step    (step)
    );

    tfcc_ring_ram #(
        .DATA_W (tfcc_pkg::PAIR_DW),
        .DEPTH  (tfcc_pkg::PAIR_DEPTH)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_pair)
    );

    // The RAM returns the old word when the same pair is written in the cycle
    // it is read; that only happens with an empty ring, where the tag just
    // stored is taken from the forwarded copy instead.
    assign head_byte = s1_half_reg ? rd_pair[tfcc_pkg::PAIR_DW-1:tfcc_pkg::BYTE_W]
                                   : rd_pair[tfcc_pkg::BYTE_W-1:0];

    assign result_valid    = s1_valid_reg;
    assign send_valid      = s1_send_reg;
    assign send_byte       = !s1_send_reg ? '0 : (s1_fwd_reg ? s1_fwd_byte_reg : head_byte);
    assign arrival_dropped = s1_drop_reg;
    assign fill_level      = s1_fill_reg;

`ifndef SYNTH
    // The ring never reports more bytes than it can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (fill_level <= tfcc_pkg::FILL_W'(tfcc_pkg::RING_DEPTH)))
        else $error("fill level above ring depth");

    // A dropped arrival means the ring was nearly full, less at most one send.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && arrival_dropped) |->
            (fill_level >= tfcc_pkg::FILL_W'(tfcc_pkg::RING_DEPTH - 2)))
        else $error("arrival dropped with room in the ring");

    // A result without a send carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !send_valid) |-> (send_byte == '0))
        else $error("byte present without a send");

    // Requests are held back only while a finished result waits downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall && s0_valid_reg))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
